// ===== hdl/rss_pkg.sv =====
// Package for the record substring scan block.
// Holds field widths, configuration register indexes and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

  localparam int BYTE_W        = 8;
  localparam int FIELD_W       = 24;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_IDX_W     = 3;
  localparam int QLEN_W        = 6;
  localparam int QUERY_REGS    = 4;
  localparam int BYTES_PER_REG = 8;
  localparam int QUERY_BYTES   = QUERY_REGS * BYTES_PER_REG;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_0   = 3'd0,
    CFG_QUERY_1   = 3'd1,
    CFG_QUERY_2   = 3'd2,
    CFG_QUERY_3   = 3'd3,
    CFG_QUERY_LEN = 3'd4
  } cfg_reg_e;

  // per-item controls broadcast to every cell, already gated by the input handshake
  typedef struct packed {
    logic start;   // clear vector before the byte
    logic update;  // present byte with a non-empty query
    logic clear;   // end of name, clear after the byte
  } cell_ctrl_t;

endpackage

// ===== hdl/record_substring_scan.sv =====
// Top level of the record substring scan: config registers, cell chain, result register.
// Depends on rss_pkg and rss_cell.
`timescale 1ns / 1ps

// Streams record names one item per clock and reports every record whose name contains
// the configured query (up to QUERY_MAX bytes; an empty query matches every record).
// One item is taken every cycle: the QUERY_MAX match cells compare the byte against their
// query byte and shift the partial-match bit along the chain. A result appears in the
// output register the cycle after its end-of-name item is taken; input stalls only while
// that register holds a result that has not been taken. The slot count restarts on
// scan_start and saturates at 2^INDEX_BITS - 1. Configuration writes take effect from
// the next item.

module record_substring_scan #(
  parameter int QUERY_MAX  = 32,
  parameter int INDEX_BITS = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rss_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [rss_pkg::BYTE_W-1:0]     name_byte_i,
  input  logic                           byte_present_i,
  input  logic                           end_of_name_i,
  input  logic [rss_pkg::FIELD_W-1:0]    record_index_i,
  input  logic                           scan_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [rss_pkg::FIELD_W-1:0]    matched_index_o,
  output logic [rss_pkg::FIELD_W-1:0]    match_slot_o
);

  localparam int LEN_BITS = $clog2(QUERY_MAX + 1);
  localparam logic [rss_pkg::FIELD_W-1:0] IDX_MASK =
    rss_pkg::FIELD_W'((64'd1 << INDEX_BITS) - 64'd1);
  localparam logic [INDEX_BITS-1:0] CNT_MAX = '1;

  logic [rss_pkg::CFG_DATA_W-1:0] query_q [rss_pkg::QUERY_REGS];
  logic [rss_pkg::QLEN_W-1:0]     qlen_q;
  logic [LEN_BITS-1:0]            eff_len;

  logic                           found_q;
  logic                           found_d;
  logic                           found_base;
  logic [INDEX_BITS-1:0]          count_q;
  logic [INDEX_BITS-1:0]          count_d;
  logic [INDEX_BITS-1:0]          count_base;

  logic                           out_valid_q;
  logic                           out_valid_d;
  logic [rss_pkg::FIELD_W-1:0]    index_q;
  logic [rss_pkg::FIELD_W-1:0]    index_d;
  logic [rss_pkg::FIELD_W-1:0]    slot_q;
  logic [rss_pkg::FIELD_W-1:0]    slot_d;

  logic                           accept;
  logic                           len_zero;
  logic                           hit_any;
  logic                           emit;
  rss_pkg::cell_ctrl_t            ctrl;

  logic [rss_pkg::BYTE_W-1:0]     qbyte [QUERY_MAX];
  logic [QUERY_MAX:0]             carry;
  logic [QUERY_MAX-1:0]           hits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < rss_pkg::QUERY_REGS; r++) begin
        query_q[r] <= '0;
      end
      qlen_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rss_pkg::CFG_QUERY_0:   query_q[0] <= cfg_data_i;
        rss_pkg::CFG_QUERY_1:   query_q[1] <= cfg_data_i;
        rss_pkg::CFG_QUERY_2:   query_q[2] <= cfg_data_i;
        rss_pkg::CFG_QUERY_3:   query_q[3] <= cfg_data_i;
        rss_pkg::CFG_QUERY_LEN: qlen_q     <= cfg_data_i[rss_pkg::QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_len  = (32'(qlen_q) > QUERY_MAX) ? LEN_BITS'(QUERY_MAX) : LEN_BITS'(qlen_q);
  assign len_zero = (eff_len == '0);

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign ctrl.start  = accept && scan_start_i;
  assign ctrl.update = accept && byte_present_i && !len_zero;
  assign ctrl.clear  = accept && end_of_name_i;

  assign carry[0] = 1'b1;

  for (genvar j = 0; j < QUERY_MAX; j++) begin : g_cell
    if (j < rss_pkg::QUERY_BYTES) begin : g_qb
      localparam int REG = j / rss_pkg::BYTES_PER_REG;
      localparam int OFS = (j % rss_pkg::BYTES_PER_REG) * rss_pkg::BYTE_W;
      assign qbyte[j] = query_q[REG][OFS +: rss_pkg::BYTE_W];
    end else begin : g_zero
      assign qbyte[j] = '0;
    end

    rss_cell #(
      .POS      (j),
      .LEN_BITS (LEN_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .len_i        (eff_len),
      .query_byte_i (qbyte[j]),
      .name_byte_i  (name_byte_i),
      .carry_i      (carry[j]),
      .carry_o      (carry[j+1]),
      .hit_o        (hits[j])
    );
  end

  // last cell's outgoing carry has no neighbor
  logic unused_carry;
  assign unused_carry = carry[QUERY_MAX];

  assign hit_any    = |hits;
  assign found_base = ctrl.start ? 1'b0 : found_q;
  assign count_base = ctrl.start ? '0 : count_q;
  assign emit       = ctrl.clear && (len_zero || found_base || hit_any);

  always_comb begin
    found_d = found_base | hit_any;
    if (ctrl.clear) begin
      found_d = 1'b0;
    end
    count_d = count_base;
    if (emit && (count_base != CNT_MAX)) begin
      count_d = count_base + INDEX_BITS'(1);
    end
    out_valid_d = out_valid_q && !out_ready_i;
    index_d     = index_q;
    slot_d      = slot_q;
    if (emit) begin
      out_valid_d = 1'b1;
      index_d     = record_index_i & IDX_MASK;
      slot_d      = rss_pkg::FIELD_W'(count_base);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q     <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      found_q     <= found_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    index_q <= index_d;
    slot_q  <= slot_d;
  end

  assign out_valid_o     = out_valid_q;
  assign matched_index_o = index_q;
  assign match_slot_o    = slot_q;

endmodule

// ===== hdl/rss_cell.sv =====
// One position of the shift-and match chain: holds one partial-match bit.
// Depends on rss_pkg.
`timescale 1ns / 1ps

module rss_cell #(
  parameter int POS      = 0,
  parameter int LEN_BITS = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rss_pkg::cell_ctrl_t        ctrl_i,
  input  logic [LEN_BITS-1:0]        len_i,
  input  logic [rss_pkg::BYTE_W-1:0] query_byte_i,
  input  logic [rss_pkg::BYTE_W-1:0] name_byte_i,
  input  logic                       carry_i,
  output logic                       carry_o,
  output logic                       hit_o
);

  logic bit_q;
  logic bit_d;
  logic base;
  logic active;
  logic is_last;
  logic upd;

  assign active  = 32'(len_i) > POS;
  assign is_last = 32'(len_i) == (POS + 1);
  assign base    = ctrl_i.start ? 1'b0 : bit_q;
  assign upd     = ctrl_i.update ? (carry_i & active & (query_byte_i == name_byte_i)) : base;
  assign bit_d   = ctrl_i.clear ? 1'b0 : upd;

  // neighbor sees the vector as cleared by scan start
  assign carry_o = base;
  assign hit_o   = ctrl_i.update & upd & is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

endmodule

// ===== hdl/rss_checker.sv =====
// Port-level assertions for the record substring scan, bound to the top level.
// Depends on rss_pkg and record_substring_scan.
`timescale 1ns / 1ps

module rss_checker #(
  parameter int INDEX_BITS = 24
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           end_of_name_i,
  input logic [rss_pkg::FIELD_W-1:0]    record_index_i,
  input logic                           scan_start_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [rss_pkg::FIELD_W-1:0]    matched_index_o,
  input logic [rss_pkg::FIELD_W-1:0]    match_slot_o
);

  localparam logic [rss_pkg::FIELD_W-1:0] IDX_MASK =
    rss_pkg::FIELD_W'((64'd1 << INDEX_BITS) - 64'd1);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(matched_index_o) && $stable(match_slot_o)))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_no_result_mid_name: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !end_of_name_i && (!out_valid_o || out_ready_i)) |=> !out_valid_o)
    else $error("result without end of name");

  a_start_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && scan_start_i && end_of_name_i) |=> (!out_valid_o || match_slot_o == '0))
    else $error("first match of scan not in slot zero");

  a_index_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_of_name_i) |=>
      (!out_valid_o || matched_index_o == ($past(record_index_i) & IDX_MASK)))
    else $error("matched index does not follow item");

endmodule

bind record_substring_scan rss_checker #(.INDEX_BITS(INDEX_BITS)) u_rss_checker (.*);
